// File: rtl/core/response_timeout_table_unit_defines.svh
// Assertion macros used by the response timeout table back end.
`ifndef RESPONSE_TIMEOUT_TABLE_UNIT_DEFINES_SVH
`define RESPONSE_TIMEOUT_TABLE_UNIT_DEFINES_SVH

`ifndef SYNTHESIS

// Checks a property on every rising clock edge outside reset.
`define RTT_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);

// Checks that a condition never holds on a rising clock edge outside reset.
`define RTT_ASSERT_NEVER(lbl, clk, rstn, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) !(cond)) else $error(msg);

`else

`define RTT_ASSERT(lbl, clk, rstn, prop, msg)

`define RTT_ASSERT_NEVER(lbl, clk, rstn, cond, msg)

`endif

`endif

// File: rtl/core/rtt_pkg.sv
// Types and constants of the response timeout table.
`timescale 1ns / 1ps
package rtt_pkg;

  localparam int unsigned NumSlots   = 5;
  localparam int unsigned QueueDepth = 2;

  localparam logic [15:0] LimitReset = 16'd10;
  localparam logic [31:0] TimeMax    = 32'hFFFF_FFFF;

  localparam logic OPC_REGISTER = 1'b0;
  localparam logic OPC_TICK     = 1'b1;

  typedef enum logic [1:0] {
    ST_STORED  = 2'd0,
    ST_FULL    = 2'd1,
    ST_EXPIRED = 2'd2,
    ST_NONE    = 2'd3
  } status_e;

  typedef enum logic {
    CMD_STORE = 1'b0,
    CMD_TICK  = 1'b1
  } cmd_e;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_SCAN,
    BK_CHECK
  } back_state_e;

  typedef struct packed {
    logic        opcode;
    logic [7:0]  device_id;
    logic [15:0] request_code;
    logic [31:0] now_ms;
  } in_word_t;

  typedef struct packed {
    status_e     status;
    logic [7:0]  expired_device;
    logic [15:0] expired_code;
    logic        last;
  } out_word_t;

  typedef struct packed {
    cmd_e        op;
    logic [7:0]  device;
    logic [15:0] code;
    logic [31:0] now;
  } cmd_t;

endpackage

// File: rtl/core/response_timeout_table_unit.sv
// Top level of the response timeout table: command front end, table back end, limit register.
//
//  channel   direction  handshake              payload
//  request   in         push / full            req_i   (in_word_t)
//  result    out        pop / empty            rsp_o   (out_word_t)
//  limit     in         cfg_we_i               cfg_wdata_i (16 bits)
//
// A register word is handled by the table sequencer once it reaches the head of the
// command queue and the result queue has room. A tick word takes E + 1 passes, where E is the
// number of expired entries: each pass walks all slots once to find the oldest entry.
// Reset clears the queues, the valid bits of the table and sets the limit to 10 ms.
// Either side may stall: a full result queue holds the sequencer, and a full command
// queue raises full.
`timescale 1ns / 1ps
module response_timeout_table_unit #(
  parameter int unsigned SLOTS = rtt_pkg::NumSlots
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push,
  output logic               full,
  input  rtt_pkg::in_word_t  req_i,
  output logic               empty,
  input  logic               pop,
  output rtt_pkg::out_word_t rsp_o,
  input  logic               cfg_we_i,
  input  logic [15:0]        cfg_wdata_i
);
  import rtt_pkg::*;

  cmd_t        cmd;
  logic        cmd_empty;
  logic        cmd_pop;
  logic [15:0] limit_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      limit_q <= LimitReset;
    end else if (cfg_we_i) begin
      limit_q <= cfg_wdata_i;
    end
  end

  rtt_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push        (push),
    .full        (full),
    .req_i       (req_i),
    .cmd_o       (cmd),
    .cmd_empty_o (cmd_empty),
    .cmd_pop_i   (cmd_pop)
  );

  rtt_back #(
    .SLOTS (SLOTS)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .cmd_empty_i (cmd_empty),
    .cmd_pop_o   (cmd_pop),
    .limit_i     (limit_q),
    .empty       (empty),
    .pop         (pop),
    .rsp_o       (rsp_o)
  );

endmodule

// File: rtl/core/rtt_fifo.sv
// Small first-in first-out queue of flip-flop entries.
`timescale 1ns / 1ps
module rtt_fifo #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 2
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] wdata_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic [WIDTH-1:0] rdata_o,
  output logic             empty_o
);

  localparam int unsigned PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CntW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [PtrW-1:0]  wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0]  rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic             do_push, do_pop;

  assign full_o  = (cnt_q == CntW'(DEPTH));
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i & ~full_o;
  assign do_pop  = pop_i & ~empty_o;
  assign rdata_o = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= wdata_i;
    end
  end

endmodule

// File: rtl/core/rtt_front.sv
// Front end: accepts input words, decodes them into commands and queues them.
`timescale 1ns / 1ps
module rtt_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push,
  output logic              full,
  input  rtt_pkg::in_word_t req_i,
  output rtt_pkg::cmd_t     cmd_o,
  output logic              cmd_empty_o,
  input  logic              cmd_pop_i
);
  import rtt_pkg::*;

  localparam int unsigned CmdW = $bits(cmd_t);

  cmd_t            cmd_d;
  logic [CmdW-1:0] cmd_rdata;

  always_comb begin
    cmd_d.device = req_i.device_id;
    cmd_d.code   = req_i.request_code;
    cmd_d.now    = req_i.now_ms;
    unique case (req_i.opcode)
      OPC_REGISTER: cmd_d.op = CMD_STORE;
      OPC_TICK:     cmd_d.op = CMD_TICK;
      default:      cmd_d.op = CMD_TICK;
    endcase
  end

  rtt_fifo #(
    .WIDTH (CmdW),
    .DEPTH (QueueDepth)
  ) u_cmd_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .wdata_i (cmd_d),
    .full_o  (full),
    .pop_i   (cmd_pop_i),
    .rdata_o (cmd_rdata),
    .empty_o (cmd_empty_o)
  );

  assign cmd_o = cmd_t'(cmd_rdata);

endmodule

// File: rtl/core/rtt_back.sv
// Back end: the pending request table, its scan sequencer and the result queue.
`timescale 1ns / 1ps
`include "response_timeout_table_unit_defines.svh"
module rtt_back #(
  parameter int unsigned SLOTS = rtt_pkg::NumSlots
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  rtt_pkg::cmd_t      cmd_i,
  input  logic               cmd_empty_i,
  output logic               cmd_pop_o,
  input  logic [15:0]        limit_i,
  output logic               empty,
  input  logic               pop,
  output rtt_pkg::out_word_t rsp_o
);
  import rtt_pkg::*;

  localparam int unsigned SlotW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int unsigned RspW  = $bits(out_word_t);

  back_state_e state_q, state_d;

  logic [SLOTS-1:0] valid_q;
  logic [31:0]      time_q [SLOTS];
  logic [7:0]       dev_q  [SLOTS];
  logic [15:0]      code_q [SLOTS];

  logic [31:0]      now_q;
  logic [31:0]      best_q;
  logic [SlotW-1:0] best_idx_q;
  logic [7:0]       best_dev_q;
  logic [15:0]      best_code_q;
  logic             found_q;
  logic [SlotW-1:0] scan_idx_q;
  logic             held_v_q;
  logic [7:0]       held_dev_q;
  logic [15:0]      held_code_q;

  logic             any_free;
  logic [SlotW-1:0] free_idx;
  logic [31:0]      elapsed;
  logic             expired;
  logic             scan_hit;

  logic             do_store, do_tick_start, do_free, scan_last;
  logic             rsp_push, rsp_full;
  out_word_t        rsp_word;
  logic [RspW-1:0]  rsp_rdata;

  // Lowest free slot wins, so scan from the top down.
  always_comb begin
    any_free = 1'b0;
    free_idx = '0;
    for (int i = SLOTS - 1; i >= 0; i--) begin
      if (!valid_q[i]) begin
        any_free = 1'b1;
        free_idx = SlotW'(i);
      end
    end
  end

  // Less-or-equal lets the highest slot win a tie on the timestamp.
  assign scan_hit  = valid_q[scan_idx_q] && (time_q[scan_idx_q] <= best_q);
  assign scan_last = (scan_idx_q == SlotW'(SLOTS - 1));
  assign elapsed   = now_q - best_q;
  assign expired   = found_q && (elapsed > {16'd0, limit_i});

  always_comb begin
    state_d       = state_q;
    cmd_pop_o     = 1'b0;
    rsp_push      = 1'b0;
    rsp_word      = '{status: ST_NONE, expired_device: '0, expired_code: '0, last: 1'b1};
    do_store      = 1'b0;
    do_tick_start = 1'b0;
    do_free       = 1'b0;
    unique case (state_q)
      BK_IDLE: begin
        if (!cmd_empty_i) begin
          if (cmd_i.op == CMD_TICK) begin
            cmd_pop_o     = 1'b1;
            do_tick_start = 1'b1;
            state_d       = BK_SCAN;
          end else if (!rsp_full) begin
            cmd_pop_o       = 1'b1;
            rsp_push        = 1'b1;
            do_store        = any_free;
            rsp_word.status = any_free ? ST_STORED : ST_FULL;
          end
        end
      end
      BK_SCAN: begin
        if (scan_last) begin
          state_d = BK_CHECK;
        end
      end
      BK_CHECK: begin
        if (expired) begin
          // The previous report is released only once another one follows it.
          if (!held_v_q || !rsp_full) begin
            rsp_push = held_v_q;
            rsp_word = '{status: ST_EXPIRED, expired_device: held_dev_q,
                         expired_code: held_code_q, last: 1'b0};
            do_free  = 1'b1;
            state_d  = BK_SCAN;
          end
        end else if (!rsp_full) begin
          rsp_push = 1'b1;
          if (held_v_q) begin
            rsp_word = '{status: ST_EXPIRED, expired_device: held_dev_q,
                         expired_code: held_code_q, last: 1'b1};
          end
          state_d = BK_IDLE;
        end
      end
      default: state_d = BK_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= BK_IDLE;
      valid_q    <= '0;
      found_q    <= 1'b0;
      held_v_q   <= 1'b0;
      scan_idx_q <= '0;
    end else begin
      state_q <= state_d;
      if (do_store) begin
        valid_q[free_idx] <= 1'b1;
      end
      if (do_free) begin
        valid_q[best_idx_q] <= 1'b0;
      end
      if (do_tick_start) begin
        held_v_q <= 1'b0;
      end else if (do_free) begin
        held_v_q <= 1'b1;
      end
      if (do_tick_start || do_free) begin
        found_q    <= 1'b0;
        scan_idx_q <= '0;
      end else if (state_q == BK_SCAN) begin
        if (scan_hit) begin
          found_q <= 1'b1;
        end
        if (!scan_last) begin
          scan_idx_q <= scan_idx_q + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_store) begin
      time_q[free_idx] <= cmd_i.now;
      dev_q[free_idx]  <= cmd_i.device;
      code_q[free_idx] <= cmd_i.code;
    end
    if (do_tick_start) begin
      now_q <= cmd_i.now;
    end
    if (do_tick_start || do_free) begin
      best_q <= TimeMax;
    end else if (state_q == BK_SCAN && scan_hit) begin
      best_q      <= time_q[scan_idx_q];
      best_idx_q  <= scan_idx_q;
      best_dev_q  <= dev_q[scan_idx_q];
      best_code_q <= code_q[scan_idx_q];
    end
    if (do_free) begin
      held_dev_q  <= best_dev_q;
      held_code_q <= best_code_q;
    end
  end

  rtt_fifo #(
    .WIDTH (RspW),
    .DEPTH (QueueDepth)
  ) u_rsp_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (rsp_push),
    .wdata_i (rsp_word),
    .full_o  (rsp_full),
    .pop_i   (pop),
    .rdata_o (rsp_rdata),
    .empty_o (empty)
  );

  assign rsp_o = out_word_t'(rsp_rdata);

  `RTT_ASSERT_NEVER(a_no_push_when_full, clk_i, rst_ni, rsp_push && rsp_full, "result queue overrun")
  `RTT_ASSERT(a_freed_slot_cleared, clk_i, rst_ni, do_free |=> !valid_q[$past(best_idx_q)], "freed slot still valid")
  `RTT_ASSERT(a_free_only_found, clk_i, rst_ni, do_free |-> (found_q && valid_q[best_idx_q]), "freeing a slot that was not found")
  `RTT_ASSERT(a_scan_in_range, clk_i, rst_ni, (state_q == BK_SCAN) |-> (scan_idx_q <= SlotW'(SLOTS - 1)), "scan index out of range")

endmodule
